// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL top level; define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on clk, ignored while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on clk in every cycle, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_CLK_ALWAYS(label, prop, msg)
`endif

`endif

// ===== hw/rtl/htfd_pkg.sv =====
// Types and constants of the humidity/temperature frame decoder.
package htfd_pkg;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_TEMP_CRC  = 2'd1,
		STATUS_HUMID_CRC = 2'd2
	} status_t;

	// One checked frame, handed from the front end to the scaling back end.
	typedef struct packed {
		status_t     status;
		logic [15:0] temp_word;
		logic [15:0] humid_raw;
	} job_t;

	// byte positions within one six-byte frame
	localparam logic [2:0] POS_T_MSB  = 3'd0;
	localparam logic [2:0] POS_T_LSB  = 3'd1;
	localparam logic [2:0] POS_T_CRC  = 3'd2;
	localparam logic [2:0] POS_H_MSB  = 3'd3;
	localparam logic [2:0] POS_H_LSB  = 3'd4;
	localparam logic [2:0] POS_H_CRC  = 3'd5;

	localparam logic [7:0]  CRC_INIT    = 8'hFF;
	localparam logic [7:0]  CRC_POLY    = 8'h31;
	localparam logic [14:0] TEMP_SPAN   = 15'd17500;
	localparam logic [16:0] RAW_FULL    = 17'd65535;
	localparam logic [14:0] TEMP_OFFSET = 15'd4500;
	localparam logic [13:0] HUMID_SPAN  = 14'd10000;

endpackage

// ===== hw/rtl/htfd_front.sv =====
// Front end: byte position tracking, CRC-8 checks and frame capture.
module htfd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  logic [7:0]      rx_byte,
	input  logic            frame_start,
	output logic            job_valid,
	output htfd_pkg::job_t  job
);

	function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ htfd_pkg::CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	logic [2:0]  pos_q, pos_eff, pos_nxt;
	logic [7:0]  crc_q, crc_nxt, crc_base, crc_fed;
	logic [15:0] temp_q, temp_nxt;
	logic [15:0] humid_q, humid_nxt;
	logic        tfail_q, tfail_nxt;
	logic        last_byte;

	always_comb begin
		// a start mark, or a position that cannot arise, restarts the frame
		pos_eff  = (frame_start || pos_q > htfd_pkg::POS_H_CRC) ? htfd_pkg::POS_T_MSB : pos_q;
		crc_base = (pos_eff == htfd_pkg::POS_T_MSB) ? htfd_pkg::CRC_INIT : crc_q;
		crc_fed  = crc8_feed(crc_base, rx_byte);

		crc_nxt   = crc_q;
		temp_nxt  = temp_q;
		humid_nxt = humid_q;
		tfail_nxt = tfail_q;
		last_byte = 1'b0;
		job.status    = htfd_pkg::STATUS_OK;
		job.temp_word = temp_q;
		job.humid_raw = humid_q;

		unique case (pos_eff)
			htfd_pkg::POS_T_MSB: begin
				temp_nxt  = {rx_byte, 8'h00};
				crc_nxt   = crc_fed;
				tfail_nxt = 1'b0;
			end
			htfd_pkg::POS_T_LSB: begin
				temp_nxt = {temp_q[15:8], rx_byte};
				crc_nxt  = crc_fed;
			end
			htfd_pkg::POS_T_CRC: begin
				tfail_nxt = (crc_q != rx_byte);
				crc_nxt   = htfd_pkg::CRC_INIT;
			end
			htfd_pkg::POS_H_MSB: begin
				humid_nxt = {rx_byte, 8'h00};
				crc_nxt   = crc_fed;
			end
			htfd_pkg::POS_H_LSB: begin
				humid_nxt = {humid_q[15:8], rx_byte};
				crc_nxt   = crc_fed;
			end
			htfd_pkg::POS_H_CRC: begin
				last_byte = 1'b1;
				crc_nxt   = htfd_pkg::CRC_INIT;
				// temperature failure takes priority
				priority if (tfail_q) begin
					job.status = htfd_pkg::STATUS_TEMP_CRC;
				end else if (crc_q != rx_byte) begin
					job.status = htfd_pkg::STATUS_HUMID_CRC;
				end else begin
					job.status = htfd_pkg::STATUS_OK;
				end
			end
			default: begin
				crc_nxt = crc_q;
			end
		endcase

		pos_nxt   = (pos_eff >= htfd_pkg::POS_H_CRC) ? htfd_pkg::POS_T_MSB : pos_eff + 3'd1;
		job_valid = fire && last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= htfd_pkg::POS_T_MSB;
			crc_q   <= htfd_pkg::CRC_INIT;
			temp_q  <= '0;
			humid_q <= '0;
			tfail_q <= 1'b0;
		end else if (fire) begin
			pos_q   <= pos_nxt;
			crc_q   <= crc_nxt;
			temp_q  <= temp_nxt;
			humid_q <= humid_nxt;
			tfail_q <= tfail_nxt;
		end
	end

endmodule

// ===== hw/rtl/htfd_fifo.sv =====
// Two-entry job queue between front end and back end.
module htfd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  htfd_pkg::job_t  push_job,
	output logic            full,
	output logic            pop_valid,
	input  logic            pop_ready,
	output htfd_pkg::job_t  pop_job
);

	htfd_pkg::job_t mem_q [2];
	logic           wr_ptr_q, rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_push, do_pop;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_job   = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/htfd_back.sv =====
// Back end: scaling to centidegrees and centipercent, output register.
module htfd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	output logic            job_ready,
	input  htfd_pkg::job_t  job,
	output logic            result_valid,
	input  logic            result_stall,
	output logic [1:0]      status,
	output logic [14:0]     temp_centideg,
	output logic [13:0]     humidity_centipct
);

	logic               valid_s1;
	htfd_pkg::status_t  status_s1;
	logic [30:0]        temp_prod_s1;
	logic [29:0]        humid_prod_s1;

	logic               valid_s2;
	logic [1:0]         status_s2;
	logic [14:0]        temp_s2;
	logic [13:0]        humid_s2;

	logic               advance;
	logic [14:0]        tq0, tq;
	logic [16:0]        trem;
	logic [13:0]        hq0, hq;
	logic [16:0]        hrem;
	logic               ok_s1;

	assign advance   = !valid_s2 || !result_stall;
	assign job_ready = !valid_s1 || advance;

	// x / 65535 with x < 2^31: q0 = x >> 16, remainder lo + q0 stays below 2 * 65535
	always_comb begin
		tq0  = temp_prod_s1[30:16];
		trem = {1'b0, temp_prod_s1[15:0]} + {2'b00, tq0};
		tq   = tq0 + ((trem >= htfd_pkg::RAW_FULL) ? 15'd1 : 15'd0);
		hq0  = humid_prod_s1[29:16];
		hrem = {1'b0, humid_prod_s1[15:0]} + {3'b000, hq0};
		hq   = hq0 + ((hrem >= htfd_pkg::RAW_FULL) ? 14'd1 : 14'd0);
		ok_s1 = (status_s1 == htfd_pkg::STATUS_OK);
	end

	always_ff @(posedge clk) begin
		if (job_ready && job_valid) begin
			status_s1     <= job.status;
			temp_prod_s1  <= 31'(job.temp_word) * 31'(htfd_pkg::TEMP_SPAN);
			humid_prod_s1 <= 30'(job.humid_raw) * 30'(htfd_pkg::HUMID_SPAN);
		end
		if (advance && valid_s1) begin
			status_s2 <= status_s1;
			temp_s2   <= ok_s1 ? (tq - htfd_pkg::TEMP_OFFSET) : 15'd0;
			humid_s2  <= ok_s1 ? hq : 14'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (job_ready) begin
				valid_s1 <= job_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	assign result_valid      = valid_s2;
	assign status            = status_s2;
	assign temp_centideg     = temp_s2;
	assign humidity_centipct = humid_s2;

endmodule

// ===== hw/rtl/humidity_temp_frame_decoder.sv =====
// Top level of the humidity/temperature frame decoder.

// Decodes six-byte sensor measurement frames (temperature MSB, LSB, CRC, then
// humidity MSB, LSB, CRC), taking one byte per transfer on the byte channel and
// giving one result transfer per completed frame. Each word is checked with
// CRC-8 (poly 0x31, init 0xFF); on success the result carries the temperature
// in centidegrees (raw*17500/65535-4500) and the humidity in centipercent
// (raw*10000/65535), on failure a status code (temperature failure wins) with
// zero values. frame_start restarts the frame at any byte; a partial frame is
// dropped silently. Rate: one byte per clock while byte_stall is low; the front
// end checks CRC and tracks position as each byte is taken. The frame's last
// byte writes the two-entry job queue; the job then loads the multiplier stage
// and then the divide-by-65535 and output stage, whose register drives
// result_valid. byte_stall rises only when the job queue is full, which happens
// only while the result side holds off.
module humidity_temp_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  rx_byte,
	input  logic        frame_start,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  status,
	output logic [14:0] temp_centideg,
	output logic [13:0] humidity_centipct
);

`include "assert_macros.svh"

	logic           fire;
	logic           front_job_valid;
	htfd_pkg::job_t front_job;
	logic           fifo_full;
	logic           fifo_valid;
	logic           back_ready;
	htfd_pkg::job_t fifo_job;

	// conservative stall: a queue slot is always free for a frame's last byte
	assign byte_stall = fifo_full;
	assign fire       = byte_valid && !byte_stall;

	htfd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.job_valid   (front_job_valid),
		.job         (front_job)
	);

	htfd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_job_valid),
		.push_job  (front_job),
		.full      (fifo_full),
		.pop_valid (fifo_valid),
		.pop_ready (back_ready),
		.pop_job   (fifo_job)
	);

	htfd_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.job_valid         (fifo_valid),
		.job_ready         (back_ready),
		.job               (fifo_job),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.status            (status),
		.temp_centideg     (temp_centideg),
		.humidity_centipct (humidity_centipct)
	);

	// error results carry zero values
	`ASSERT_CLK(a_err_zero, (result_valid && status != htfd_pkg::STATUS_OK) |-> (temp_centideg == 15'd0 && humidity_centipct == 14'd0), "error result with non-zero values")
	// good results stay within the sensor range
	`ASSERT_CLK(a_ok_range, (result_valid && status == htfd_pkg::STATUS_OK) |-> (humidity_centipct <= 14'd10000 && $signed(temp_centideg) >= -15'sd4500 && $signed(temp_centideg) <= 15'sd13000), "result out of range")
	// no status beyond the humidity code is ever produced
	`ASSERT_CLK(a_status_code, result_valid |-> (status <= htfd_pkg::STATUS_HUMID_CRC), "undefined status code")
	// a job pushed into the queue is never dropped on a full queue
	`ASSERT_CLK_ALWAYS(a_no_overflow, !(front_job_valid && fifo_full), "job lost on full queue")

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the humidity/temperature frame decoder.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS  = 700;
	localparam int DIRECTED_ROWS = 25;
	localparam int CYCLE_LIMIT   = 200000;
	// Long result hold-off: far more than enough to fill the job queue
	// and both back-end stages, so byte_stall must rise.
	localparam int LONG_HOLD     = 300;
	localparam int TAIL_CYCLES   = 20;

	typedef struct packed {
		htfd_pkg::status_t  st;
		logic signed [14:0] temp;
		logic [13:0]        humid;
	} reading_t;

	// One byte transfer; on rows marked as typed the reading is written
	// out by hand rather than taken from the predictor.
	typedef struct packed {
		logic       typed;
		logic       start;
		logic [7:0] data;
		reading_t   want;
	} byte_row_t;

	localparam reading_t NO_READING = '{htfd_pkg::STATUS_OK, 15'sd0, 14'd0};

	// Directed frames. CRC of 0x0000 is 0x81, of 0xFFFF is 0xAC.
	localparam byte_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
		// all-zero words, frame opened by the start mark: coldest, driest
		'{1'b0, 1'b1, 8'h00, NO_READING},
		'{1'b0, 1'b0, 8'h00, NO_READING},
		'{1'b0, 1'b0, 8'h81, NO_READING},
		'{1'b0, 1'b0, 8'h00, NO_READING},
		'{1'b0, 1'b0, 8'h00, NO_READING},
		'{1'b1, 1'b0, 8'h81, '{htfd_pkg::STATUS_OK, -15'sd4500, 14'd0}},
		// full-scale words, no start mark: position 0 opens the frame anyway
		'{1'b0, 1'b0, 8'hFF, NO_READING},
		'{1'b0, 1'b0, 8'hFF, NO_READING},
		'{1'b0, 1'b0, 8'hAC, NO_READING},
		'{1'b0, 1'b0, 8'hFF, NO_READING},
		'{1'b0, 1'b0, 8'hFF, NO_READING},
		'{1'b1, 1'b0, 8'hAC, '{htfd_pkg::STATUS_OK, 15'sd13000, 14'd10000}},
		// lone byte, then a start mark mid-frame drops it silently
		'{1'b0, 1'b1, 8'h12, NO_READING},
		// both checks wrong: temperature failure wins
		'{1'b0, 1'b1, 8'h00, NO_READING},
		'{1'b0, 1'b0, 8'h00, NO_READING},
		'{1'b0, 1'b0, 8'h00, NO_READING},
		'{1'b0, 1'b0, 8'hFF, NO_READING},
		'{1'b0, 1'b0, 8'hFF, NO_READING},
		'{1'b1, 1'b0, 8'h00, '{htfd_pkg::STATUS_TEMP_CRC, 15'sd0, 14'd0}},
		// temperature good, humidity check wrong
		'{1'b0, 1'b0, 8'hFF, NO_READING},
		'{1'b0, 1'b0, 8'hFF, NO_READING},
		'{1'b0, 1'b0, 8'hAC, NO_READING},
		'{1'b0, 1'b0, 8'h00, NO_READING},
		'{1'b0, 1'b0, 8'h00, NO_READING},
		'{1'b1, 1'b0, 8'h00, '{htfd_pkg::STATUS_HUMID_CRC, 15'sd0, 14'd0}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        frame_start = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [1:0]  status;
	logic [14:0] temp_centideg;
	logic [13:0] humidity_centipct;

	// Predictor state, reset values as after arst_n
	logic [2:0]  frame_pos = htfd_pkg::POS_T_MSB;
	logic [7:0]  word_crc  = htfd_pkg::CRC_INIT;
	logic [15:0] temp_word = 16'h0000;
	logic [15:0] humid_raw = 16'h0000;
	logic        temp_bad  = 1'b0;

	reading_t pending_readings[$];

	int mismatches = 0;
	int bytes_sent = 0;
	int readings_checked = 0;
	int status_seen [3] = '{0, 0, 0};
	int cycles = 0;
	bit long_hold_done = 1'b0;

	humidity_temp_frame_decoder DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.byte_valid        (byte_valid),
		.byte_stall        (byte_stall),
		.rx_byte           (rx_byte),
		.frame_start       (frame_start),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.status            (status),
		.temp_centideg     (temp_centideg),
		.humidity_centipct (humidity_centipct)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// CRC-8, poly 0x31, MSB first, one byte at a time
	function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		int         k;
		c = crc ^ b;
		for (k = 0; k < 8; k++)
			c = c[7] ? ((c << 1) ^ htfd_pkg::CRC_POLY) : (c << 1);
		return c;
	endfunction

	// Advance the frame decoder by one byte; returns 1 when the byte closes a
	// frame, with the expected reading in r.
	function automatic bit decode_byte(input logic [7:0] b, input logic start,
			output reading_t r);
		logic [2:0]  pos;
		logic [31:0] scaled;
		bit          closed;
		closed = 1'b0;
		r = NO_READING;
		// a start mark, or a position out of range, restarts the frame
		pos = (start || frame_pos > htfd_pkg::POS_H_CRC) ? htfd_pkg::POS_T_MSB : frame_pos;
		if (pos == htfd_pkg::POS_T_MSB) begin
			word_crc = htfd_pkg::CRC_INIT;
			temp_bad = 1'b0;
		end
		case (pos)
			htfd_pkg::POS_T_MSB: begin
				temp_word = {b, 8'h00};
				word_crc = crc8_feed(word_crc, b);
			end
			htfd_pkg::POS_T_LSB: begin
				temp_word[7:0] = b;
				word_crc = crc8_feed(word_crc, b);
			end
			htfd_pkg::POS_T_CRC: begin
				temp_bad = (word_crc != b);
				word_crc = htfd_pkg::CRC_INIT;
			end
			htfd_pkg::POS_H_MSB: begin
				humid_raw = {b, 8'h00};
				word_crc = crc8_feed(word_crc, b);
			end
			htfd_pkg::POS_H_LSB: begin
				humid_raw[7:0] = b;
				word_crc = crc8_feed(word_crc, b);
			end
			default: begin
				if (temp_bad) begin
					r.st = htfd_pkg::STATUS_TEMP_CRC;
				end else if (word_crc != b) begin
					r.st = htfd_pkg::STATUS_HUMID_CRC;
				end else begin
					scaled = 32'(temp_word) * 32'(htfd_pkg::TEMP_SPAN)
						/ 32'(htfd_pkg::RAW_FULL) - 32'(htfd_pkg::TEMP_OFFSET);
					r.temp = scaled[14:0];
					scaled = 32'(humid_raw) * 32'(htfd_pkg::HUMID_SPAN)
						/ 32'(htfd_pkg::RAW_FULL);
					r.humid = scaled[13:0];
				end
				word_crc = htfd_pkg::CRC_INIT;
				closed = 1'b1;
			end
		endcase
		frame_pos = (pos >= htfd_pkg::POS_H_CRC) ? htfd_pkg::POS_T_MSB : pos + 3'd1;
		return closed;
	endfunction

	// Raw sensor word, with the ends of the range drawn now and then
	function automatic logic [15:0] draw_word();
		case ($urandom_range(0, 9))
			0: begin
				return 16'h0000;
			end
			1: begin
				return 16'hFFFF;
			end
			default: begin
				return 16'($urandom);
			end
		endcase
	endfunction

	// Run limit, counted from time zero
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles, %0d readings pending",
				cycles, pending_readings.size());
			$display("tb: done, errors");
			$finish;
		end
	end

	// Result side: every accepted transfer is matched against the oldest
	// pending reading. Outputs and result_stall are read as they stood
	// just before the edge.
	always @(posedge clk) begin
		reading_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_readings.size() == 0) begin
				$error("unexpected result: status %0d temp %0d humid %0d",
					status, $signed(temp_centideg), humidity_centipct);
				mismatches++;
			end else begin
				want = pending_readings.pop_front();
				readings_checked++;
				if (want.st <= htfd_pkg::STATUS_HUMID_CRC)
					status_seen[want.st]++;
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					mismatches++;
				end
				if (temp_centideg !== want.temp) begin
					$error("temp_centideg: expected %0d, got %0d",
						want.temp, $signed(temp_centideg));
					mismatches++;
				end
				if (humidity_centipct !== want.humid) begin
					$error("humidity_centipct: expected %0d, got %0d",
						want.humid, humidity_centipct);
					mismatches++;
				end
			end
		end
	end

	// Result-side stall pattern: a random hold-off before each
	// transfer, runs of no hold-off at all, and once a long hold-off so that
	// the block backs up and stalls the byte side.
	initial begin : result_taker
		int  hold;
		int  taken;
		bit  quiet;
		taken = 0;
		quiet = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (taken % 20 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			hold = quiet ? 0 : $urandom_range(0, 8);
			if (!long_hold_done && readings_checked >= 40) begin
				hold = LONG_HOLD;
				long_hold_done = 1'b1;
			end
			if (hold != 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			@(posedge clk);
			while (!result_valid)
				@(posedge clk);
			taken++;
		end
	end

	// Byte side: builds the whole stimulus list, then offers it one transfer
	// at a time and runs the predictor on each accepted byte.
	initial begin : byte_sender
		byte_row_t   rows[$];
		byte_row_t   row;
		logic [7:0]  frame [6];
		logic [15:0] t_word;
		logic [15:0] h_word;
		reading_t    got;
		int          kind;
		int          len;
		int          gap;
		int          i;
		int          j;
		int          pause_at;
		bit          resync;
		bit          quiet;
		bit          drain;

		foreach (DIRECTED[n])
			rows.push_back(DIRECTED[n]);

		// Random frames: mostly well-formed with random words, some with a bad
		// check byte, some cut short and followed by up to three stray bytes. After
		// a cut-short frame the next one carries the start mark so the decoder realigns.
		resync = 1'b0;
		while (rows.size() < DIRECTED_ROWS + RANDOM_ITEMS) begin
			kind = $urandom_range(0, 99);
			t_word = draw_word();
			h_word = draw_word();
			frame[0] = t_word[15:8];
			frame[1] = t_word[7:0];
			frame[2] = crc8_feed(crc8_feed(htfd_pkg::CRC_INIT, t_word[15:8]), t_word[7:0]);
			frame[3] = h_word[15:8];
			frame[4] = h_word[7:0];
			frame[5] = crc8_feed(crc8_feed(htfd_pkg::CRC_INIT, h_word[15:8]), h_word[7:0]);
			if (kind >= 70 && kind < 78)
				frame[2] ^= 8'($urandom_range(1, 255));
			else if (kind >= 78 && kind < 86)
				frame[5] ^= 8'($urandom_range(1, 255));
			else if (kind >= 86 && kind < 90) begin
				frame[2] ^= 8'($urandom_range(1, 255));
				frame[5] ^= 8'($urandom_range(1, 255));
			end
			len = (kind >= 90) ? $urandom_range(1, 5) : 6;
			for (j = 0; j < len; j++) begin
				row = '{1'b0, 1'b0, frame[j], NO_READING};
				if (j == 0)
					row.start = resync | 1'($urandom_range(0, 1));
				rows.push_back(row);
			end
			resync = (kind >= 90);
			if (resync) begin
				for (j = $urandom_range(0, 3); j > 0; j--) begin
					row = '{1'b0, 1'($urandom_range(0, 1)), 8'($urandom), NO_READING};
					rows.push_back(row);
				end
			end
		end

		pause_at = DIRECTED_ROWS + RANDOM_ITEMS / 2;
		quiet = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < rows.size(); i++) begin
			if (i % 40 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			gap = quiet ? 0 : $urandom_range(0, 8);
			// after the directed part and once midway the sender goes quiet
			// until every pending reading has been seen
			drain = (i == DIRECTED_ROWS || i == pause_at);
			if (drain && gap == 0)
				gap = 1;
			if (gap != 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
				if (drain)
					while (pending_readings.size() != 0)
						@(posedge clk);
			end
			byte_valid  <= 1'b1;
			rx_byte     <= rows[i].data;
			frame_start <= rows[i].start;
			@(posedge clk);
			while (byte_stall)
				@(posedge clk);
			// transfer taken at this edge
			bytes_sent++;
			if (decode_byte(rows[i].data, rows[i].start, got)) begin
				if (rows[i].typed)
					got = rows[i].want;
				pending_readings.push_back(got);
			end
		end
		byte_valid <= 1'b0;

		while (pending_readings.size() != 0)
			@(posedge clk);
		// the pipeline is three deep; allow a little more for stray results
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("tb: %0d bytes in, %0d readings checked: %0d ok, %0d temp crc, %0d humid crc",
			bytes_sent, readings_checked, status_seen[htfd_pkg::STATUS_OK],
			status_seen[htfd_pkg::STATUS_TEMP_CRC], status_seen[htfd_pkg::STATUS_HUMID_CRC]);
		$display("tb: long result hold-off %0s, two full drains, %0d mismatches",
			long_hold_done ? "done" : "missed", mismatches);
		if (mismatches == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/htfd_pkg.sv
hw/rtl/htfd_front.sv
hw/rtl/htfd_fifo.sv
hw/rtl/htfd_back.sv
hw/rtl/humidity_temp_frame_decoder.sv
bench/tb.sv
